/* rtl/core/ipc_pkg.sv */
// Package for the irrigation pivot controller: beat structs, state codes,
// thresholds and register defaults. Depends on nothing.
`default_nettype none

package ipc_pkg;

  // Control states, as reported in state_code
  typedef enum logic [2:0] {
    ST_CONFIG = 3'd0,
    ST_INIT   = 3'd1,
    ST_FAULT  = 3'd2,
    ST_MOVE   = 3'd3,
    ST_WATER  = 3'd4,
    ST_END    = 3'd5,
    ST_MANUAL = 3'd6,
    ST_CHECK  = 3'd7
  } ctrl_state_e;

  // Item kinds
  typedef enum logic [1:0] {
    FUNC_STEP = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_MODE = 2'd2
  } func_e;

  // Run modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_AUTO = 2'd1;
  localparam logic [1:0] MODE_ECO  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MOTOR_RUN = 1'b0;
  localparam logic CFG_PUMP_RUN  = 1'b1;

  localparam logic [7:0] MOTOR_RUN_MIN   = 8'd3;
  localparam logic [7:0] PUMP_RUN_MIN    = 8'd16;
  localparam logic [7:0] MOTOR_RUN_RESET = 8'd6;
  localparam logic [7:0] PUMP_RUN_RESET  = 8'd54;

  // Eco window 22:00 to 05:00, weather limits as raw counts (20 %, 40 degrees)
  localparam logic [10:0] ECO_START_MIN = 11'd1320;
  localparam logic [10:0] ECO_END_MIN   = 11'd300;
  localparam logic [11:0] HUM_DRY_RAW   = 12'd819;
  localparam logic [11:0] TEMP_HOT_RAW  = 12'd3276;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  new_mode;
    logic [5:0]  fault_lines;
    logic        manual_switch;
    logic        end_of_travel;
    logic        timer_ready;
    logic [10:0] minute_of_day;
    logic [11:0] humidity_sample;
    logic [11:0] temperature_sample;
    logic        humidity_digital;
    logic        temperature_digital;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  state_code;
    logic        motor_drive;
    logic        pump_drive;
    logic [1:0]  mode_now;
    logic [7:0]  cycles_done;
    logic [11:0] humidity_held;
    logic [11:0] temperature_held;
    logic        mode_rejected;
  } out_item_t;

  // Controller state carried between items
  typedef struct packed {
    ctrl_state_e ctrl;
    logic [1:0]  mode;
    logic [7:0]  seconds;
    logic [7:0]  cycles;
    logic [11:0] humidity;
    logic [11:0] temperature;
    logic        motor;
    logic        pump;
  } core_state_t;

  typedef struct packed {
    logic [7:0] motor_run;
    logic [7:0] pump_run;
  } run_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/irrigation_pivot_controller.sv */
// Top level of the irrigation pivot controller: input register, step logic,
// result register and run-time registers. Depends on ipc_pkg and ipc_step.
//
//   channel  direction  handshake               beat
//   in       sink       in_valid_i / in_stall_o   ipc_pkg::in_item_t
//   out      source     out_valid_o / out_stall_i ipc_pkg::out_item_t
//   cfg      sink       cfg_we_i (no wait)      cfg_index_i, cfg_data_i
//
// One item a cycle while the result side does not stall: a beat is held in the
// input register on entry, runs through the step logic and lands in the result
// register when it fires. The controller state updates in the same cycle as
// the result register loads.
// Reset puts the controller in the configuration state with mode off and all
// counters, latches and drives cleared; run times return to 6 s and 54 s.
// A stall on the result side holds the result and the waiting input beat;
// the input side stalls only while both registers are full and the result
// beat is stalled.
`default_nettype none

module irrigation_pivot_controller (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire ipc_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output ipc_pkg::out_item_t       out_item_o,
  input  wire                      cfg_we_i,
  input  wire                      cfg_index_i,
  input  wire  [7:0]               cfg_data_i
);

  logic                 in_valid_q;
  ipc_pkg::in_item_t    in_item_q;
  logic                 out_valid_q;
  ipc_pkg::out_item_t   out_item_q;
  ipc_pkg::out_item_t   out_item_d;
  ipc_pkg::core_state_t state_q;
  ipc_pkg::core_state_t state_d;
  ipc_pkg::run_cfg_t    cfg_q;
  ipc_pkg::run_cfg_t    cfg_d;
  logic                 rejected;
  logic                 fire;

  // Process the held beat when the result register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  ipc_step u_step (
    .item_i     (in_item_q),
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .state_o    (state_d),
    .rejected_o (rejected)
  );

  // Result beat reports the state after the item
  always_comb begin
    out_item_d.state_code       = state_d.ctrl;
    out_item_d.motor_drive      = state_d.motor;
    out_item_d.pump_drive       = state_d.pump;
    out_item_d.mode_now         = state_d.mode;
    out_item_d.cycles_done      = state_d.cycles;
    out_item_d.humidity_held    = state_d.humidity;
    out_item_d.temperature_held = state_d.temperature;
    out_item_d.mode_rejected    = rejected;
  end

  // Run-time registers: drop writes below the minimum
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ipc_pkg::CFG_MOTOR_RUN: begin
          if (cfg_data_i >= ipc_pkg::MOTOR_RUN_MIN) cfg_d.motor_run = cfg_data_i;
        end
        ipc_pkg::CFG_PUMP_RUN: begin
          if (cfg_data_i >= ipc_pkg::PUMP_RUN_MIN) cfg_d.pump_run = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_run <= ipc_pkg::MOTOR_RUN_RESET;
      cfg_q.pump_run  <= ipc_pkg::PUMP_RUN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Controller state: advance once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.ctrl        <= ipc_pkg::ST_CONFIG;
      state_q.mode        <= ipc_pkg::MODE_OFF;
      state_q.seconds     <= '0;
      state_q.cycles      <= '0;
      state_q.humidity    <= '0;
      state_q.temperature <= '0;
      state_q.motor       <= 1'b0;
      state_q.pump        <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* rtl/core/ipc_step.sv */
// Next-state logic of the pivot controller for one item.
// Depends on ipc_pkg.
`default_nettype none

module ipc_step (
  input  wire ipc_pkg::in_item_t    item_i,
  input  wire ipc_pkg::core_state_t state_i,
  input  wire ipc_pkg::run_cfg_t    cfg_i,
  output ipc_pkg::core_state_t      state_o,
  output logic                      rejected_o
);

  logic                  fault;
  logic                  mode_off;
  logic                  eco_window;
  logic                  weather_go;
  logic                  motor_done;
  logic                  pump_done;
  logic                  override;
  ipc_pkg::ctrl_state_e  st_pre;
  ipc_pkg::ctrl_state_e  ctrl_step;
  ipc_pkg::core_state_t  data_nxt;

  assign fault      = |item_i.fault_lines;
  assign mode_off   = (state_i.mode == ipc_pkg::MODE_OFF);
  assign eco_window = (item_i.minute_of_day >= ipc_pkg::ECO_START_MIN) ||
                      (item_i.minute_of_day <= ipc_pkg::ECO_END_MIN);
  assign weather_go = (state_i.humidity <= ipc_pkg::HUM_DRY_RAW) ||
                      (state_i.temperature >= ipc_pkg::TEMP_HOT_RAW) ||
                      (item_i.humidity_digital && item_i.temperature_digital);
  assign motor_done = (state_i.seconds >= cfg_i.motor_run);
  assign pump_done  = (state_i.seconds >= cfg_i.pump_run);

  // Fault and manual overrides, outside the configuration state
  always_comb begin
    override = 1'b0;
    st_pre   = state_i.ctrl;
    if (state_i.ctrl != ipc_pkg::ST_CONFIG && (fault || item_i.manual_switch)) begin
      override = 1'b1;
      st_pre   = fault ? ipc_pkg::ST_FAULT : ipc_pkg::ST_MANUAL;
    end
  end

  // Next control state for a control step
  always_comb begin
    ctrl_step = st_pre;
    case (st_pre)
      ipc_pkg::ST_CONFIG: begin
        if (item_i.timer_ready) ctrl_step = ipc_pkg::ST_INIT;
      end
      ipc_pkg::ST_INIT: begin
        if (state_i.mode == ipc_pkg::MODE_AUTO ||
            (state_i.mode == ipc_pkg::MODE_ECO && eco_window)) begin
          ctrl_step = ipc_pkg::ST_CHECK;
        end
      end
      ipc_pkg::ST_CHECK: begin
        if (mode_off) ctrl_step = ipc_pkg::ST_INIT;
        else if (weather_go) ctrl_step = ipc_pkg::ST_MOVE;
      end
      ipc_pkg::ST_MOVE: begin
        if (mode_off) ctrl_step = ipc_pkg::ST_INIT;
        else if (item_i.end_of_travel) ctrl_step = ipc_pkg::ST_END;
        else if (motor_done) ctrl_step = ipc_pkg::ST_WATER;
      end
      ipc_pkg::ST_WATER: begin
        if (mode_off) ctrl_step = ipc_pkg::ST_INIT;
        else if (pump_done) ctrl_step = ipc_pkg::ST_MOVE;
      end
      ipc_pkg::ST_END: begin
        ctrl_step = ipc_pkg::ST_INIT;
      end
      ipc_pkg::ST_MANUAL: begin
        if (!mode_off && !item_i.manual_switch) ctrl_step = ipc_pkg::ST_INIT;
      end
      ipc_pkg::ST_FAULT: begin
        if (mode_off) ctrl_step = ipc_pkg::ST_MANUAL;
        else if (!fault) ctrl_step = ipc_pkg::ST_INIT;
        else if (item_i.manual_switch) ctrl_step = ipc_pkg::ST_MANUAL;
      end
      default: ctrl_step = st_pre;
    endcase
  end

  // Counters, latches and drive levels
  always_comb begin
    data_nxt   = state_i;
    rejected_o = 1'b0;
    case (item_i.func)
      ipc_pkg::FUNC_STEP: begin
        if (override) begin
          data_nxt.motor = 1'b0;
          data_nxt.pump  = 1'b0;
        end
        case (st_pre)
          ipc_pkg::ST_CHECK: begin
            if (!mode_off && weather_go) begin
              data_nxt.seconds = '0;
              data_nxt.motor   = 1'b1;
            end
          end
          ipc_pkg::ST_MOVE: begin
            if (mode_off) begin
              data_nxt.motor = 1'b0;
            end else if (!item_i.end_of_travel && motor_done) begin
              data_nxt.motor   = 1'b0;
              data_nxt.seconds = '0;
              data_nxt.pump    = 1'b1;
            end
          end
          ipc_pkg::ST_WATER: begin
            if (mode_off) begin
              data_nxt.pump = 1'b0;
            end else if (pump_done) begin
              data_nxt.pump    = 1'b0;
              data_nxt.motor   = 1'b1;
              data_nxt.seconds = '0;
            end
          end
          ipc_pkg::ST_END: begin
            data_nxt.cycles = state_i.cycles + 8'd1;
            data_nxt.motor  = 1'b0;
            data_nxt.pump   = 1'b0;
          end
          default: ;
        endcase
      end
      ipc_pkg::FUNC_TICK: begin
        if (state_i.ctrl != ipc_pkg::ST_CONFIG) begin
          data_nxt.humidity    = item_i.humidity_sample;
          data_nxt.temperature = item_i.temperature_sample;
          data_nxt.seconds     = state_i.seconds + 8'd1;
        end
      end
      ipc_pkg::FUNC_MODE: begin
        if (item_i.new_mode inside {ipc_pkg::MODE_OFF, ipc_pkg::MODE_AUTO,
                                    ipc_pkg::MODE_ECO}) begin
          data_nxt.mode = item_i.new_mode;
        end else begin
          rejected_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_o = data_nxt;
    if (item_i.func == ipc_pkg::FUNC_STEP) state_o.ctrl = ctrl_step;
  end

endmodule

`default_nettype wire

/* rtl/core/ipc_checker.sv */
// Port-level checks for the irrigation pivot controller, bound to the top.
// Depends on ipc_pkg.
`default_nettype none

module ipc_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     out_valid_o,
  input wire                     out_stall_i,
  input wire ipc_pkg::out_item_t out_item_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // Never drive motor and pump together
  a_drive_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.motor_drive && out_item_o.pump_drive))
    else $error("motor and pump driven together");

  // Pump runs only while watering
  a_pump_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pump_drive |->
      out_item_o.state_code == ipc_pkg::ST_WATER)
    else $error("pump on outside watering");

  // Motor runs only while moving or at cycle end
  a_motor_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.motor_drive |->
      (out_item_o.state_code == ipc_pkg::ST_MOVE ||
       out_item_o.state_code == ipc_pkg::ST_END))
    else $error("motor on outside moving");

endmodule

bind irrigation_pivot_controller ipc_checker u_ipc_checker (.*);

`default_nettype wire

/* tb/irrigation_pivot_controller_checker.sv */
`timescale 1ns / 100ps
// Checker for the irrigation pivot controller: watches the in, out and cfg ports,
// predicts each result beat and compares it field by field. Depends on ipc_pkg.
module irrigation_pivot_controller_checker (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_stall_i,
  input  ipc_pkg::in_item_t   in_item_i,
  input  wire                 out_valid_i,
  input  wire                 out_stall_i,
  input  ipc_pkg::out_item_t  out_item_i,
  input  wire                 cfg_we_i,
  input  wire                 cfg_index_i,
  input  wire  [7:0]          cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output logic [7:0]          states_seen_o
);
  import ipc_pkg::*;

  // Predicted controller state and run times
  ctrl_state_e pv_state;
  logic [1:0]  pv_mode;
  logic [7:0]  pv_secs;
  logic [7:0]  pv_cycles;
  logic [11:0] pv_hum;
  logic [11:0] pv_temp;
  logic        pv_motor;
  logic        pv_pump;
  logic [7:0]  motor_run_s;
  logic [7:0]  pump_run_s;

  out_item_t   pivot_expected_q[$];
  out_item_t   want;
  int          mismatches;
  int          checked;
  logic [7:0]  seen;

  function automatic out_item_t predict_pivot(input in_item_t it);
    out_item_t res;
    logic      fault;
    logic      manual;
    fault  = |it.fault_lines;
    manual = it.manual_switch;
    res.mode_rejected = 1'b0;
    case (it.func)
      FUNC_STEP: begin
        // Overrides never apply in the configuration state
        if (pv_state != ST_CONFIG) begin
          if (fault) begin
            pv_motor = 1'b0;
            pv_pump  = 1'b0;
            pv_state = ST_FAULT;
          end else if (manual) begin
            pv_motor = 1'b0;
            pv_pump  = 1'b0;
            pv_state = ST_MANUAL;
          end
        end
        case (pv_state)
          ST_CONFIG: if (it.timer_ready) pv_state = ST_INIT;
          ST_INIT: begin
            if (pv_mode == MODE_AUTO) pv_state = ST_CHECK;
            else if (pv_mode == MODE_ECO && (it.minute_of_day >= ECO_START_MIN ||
                                             it.minute_of_day <= ECO_END_MIN))
              pv_state = ST_CHECK;
          end
          ST_CHECK: begin
            if (pv_mode == MODE_OFF) begin
              pv_state = ST_INIT;
            end else if (pv_hum <= HUM_DRY_RAW || pv_temp >= TEMP_HOT_RAW ||
                         (it.humidity_digital && it.temperature_digital)) begin
              pv_secs  = 8'd0;
              pv_motor = 1'b1;
              pv_state = ST_MOVE;
            end
          end
          ST_MOVE: begin
            if (pv_mode == MODE_OFF) begin
              pv_state = ST_INIT;
              pv_motor = 1'b0;
            end else if (it.end_of_travel) begin
              pv_state = ST_END;
            end else if (pv_secs >= motor_run_s) begin
              pv_motor = 1'b0;
              pv_secs  = 8'd0;
              pv_pump  = 1'b1;
              pv_state = ST_WATER;
            end
          end
          ST_WATER: begin
            if (pv_mode == MODE_OFF) begin
              pv_state = ST_INIT;
              pv_pump  = 1'b0;
            end else if (pv_secs >= pump_run_s) begin
              pv_pump  = 1'b0;
              pv_motor = 1'b1;
              pv_secs  = 8'd0;
              pv_state = ST_MOVE;
            end
          end
          ST_END: begin
            pv_cycles = pv_cycles + 8'd1;
            pv_pump   = 1'b0;
            pv_motor  = 1'b0;
            pv_state  = ST_INIT;
          end
          ST_MANUAL: if (pv_mode != MODE_OFF && !manual) pv_state = ST_INIT;
          ST_FAULT: begin
            if (pv_mode == MODE_OFF) pv_state = ST_MANUAL;
            else if (!fault) pv_state = ST_INIT;
            else if (manual) pv_state = ST_MANUAL;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (pv_state != ST_CONFIG) begin
          pv_hum  = it.humidity_sample;
          pv_temp = it.temperature_sample;
          pv_secs = pv_secs + 8'd1;
        end
      end
      FUNC_MODE: begin
        if (it.new_mode <= MODE_ECO) pv_mode = it.new_mode;
        else res.mode_rejected = 1'b1;
      end
      default: ;
    endcase
    res.state_code       = pv_state;
    res.motor_drive      = pv_motor;
    res.pump_drive       = pv_pump;
    res.mode_now         = pv_mode;
    res.cycles_done      = pv_cycles;
    res.humidity_held    = pv_hum;
    res.temperature_held = pv_temp;
    return res;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_state    = ST_CONFIG;
      pv_mode     = MODE_OFF;
      pv_secs     = 8'd0;
      pv_cycles   = 8'd0;
      pv_hum      = 12'd0;
      pv_temp     = 12'd0;
      pv_motor    = 1'b0;
      pv_pump     = 1'b0;
      motor_run_s = MOTOR_RUN_RESET;
      pump_run_s  = PUMP_RUN_RESET;
      pivot_expected_q.delete();
      mismatches  = 0;
      checked     = 0;
      seen        = 8'd0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MOTOR_RUN) begin
          if (cfg_data_i >= MOTOR_RUN_MIN) motor_run_s = cfg_data_i;
        end else if (cfg_data_i >= PUMP_RUN_MIN) begin
          pump_run_s = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) pivot_expected_q.push_back(predict_pivot(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        seen[out_item_i.state_code] = 1'b1;
        if (pivot_expected_q.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          mismatches++;
        end else begin
          want = pivot_expected_q.pop_front();
          check_field("state_code", want.state_code, out_item_i.state_code);
          check_field("motor_drive", want.motor_drive, out_item_i.motor_drive);
          check_field("pump_drive", want.pump_drive, out_item_i.pump_drive);
          check_field("mode_now", want.mode_now, out_item_i.mode_now);
          check_field("cycles_done", want.cycles_done, out_item_i.cycles_done);
          check_field("humidity_held", want.humidity_held, out_item_i.humidity_held);
          check_field("temperature_held", want.temperature_held,
                      out_item_i.temperature_held);
          check_field("mode_rejected", want.mode_rejected, out_item_i.mode_rejected);
          checked++;
        end
      end
    end
    fail_count_o  <= mismatches;
    pending_o     <= pivot_expected_q.size();
    checked_o     <= checked;
    states_seen_o <= seen;
  end

endmodule

/* tb/irrigation_pivot_controller_tb.sv */
`timescale 1ns / 100ps
// Top of the irrigation pivot controller testbench: clock, reset, stimulus and verdict.
// Depends on ipc_pkg, irrigation_pivot_controller and irrigation_pivot_controller_checker.
module irrigation_pivot_controller_tb;
  import ipc_pkg::*;

  // Codes the package leaves out: the unused item kind and the invalid mode
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_INVALID = 2'd3;
  // Cycles without any beat moving before the run is called hung
  localparam int IDLE_LIMIT = 1000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data  = 8'd0;

  int         fail_count;
  int         pending;
  int         checked;
  logic [7:0] states_seen;

  // Quiet stretches switch off idling on both sides
  logic       quiet       = 1'b0;
  int         stall_run   = 0;
  int         idle_cycles = 0;
  int         settings_done = 0;
  int         func_tally [4];

  irrigation_pivot_controller DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  irrigation_pivot_controller_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_item_i    (out_item),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .states_seen_o (states_seen)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Result side: hold stall for random stretches, release it for others
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (!quiet && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_run <= pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_run <= quiet ? 0 : $urandom_range(0, 6);
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("irrigation_pivot_controller_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t step_item(input logic [5:0] fault, input logic manual,
                                         input logic eot, input logic ready,
                                         input logic [10:0] minute, input logic hdig,
                                         input logic tdig);
    in_item_t it;
    it = '0;
    it.func                = FUNC_STEP;
    it.fault_lines         = fault;
    it.manual_switch       = manual;
    it.end_of_travel       = eot;
    it.timer_ready         = ready;
    it.minute_of_day       = minute;
    it.humidity_digital    = hdig;
    it.temperature_digital = tdig;
    return it;
  endfunction

  function automatic in_item_t tick_item(input logic [11:0] hum, input logic [11:0] temp);
    in_item_t it;
    it = '0;
    it.func               = FUNC_TICK;
    it.humidity_sample    = hum;
    it.temperature_sample = temp;
    return it;
  endfunction

  function automatic in_item_t mode_item(input logic [1:0] m);
    in_item_t it;
    it = '0;
    it.func     = FUNC_MODE;
    it.new_mode = m;
    return it;
  endfunction

  // Offer one beat after a random gap and hold it until the block takes it.
  // Stall is read straight after the edge, so it is the value the edge saw.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    func_tally[it.func]++;
  endtask

  // Drop valid and wait until every predicted result has come, then let the
  // pipeline settle a little longer
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both run times on consecutive edges; only call while drained
  task automatic write_run_times(input logic [7:0] motor_s, input logic [7:0] pump_s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MOTOR_RUN;
    cfg_data  <= motor_s;
    @(posedge clk);
    cfg_index <= CFG_PUMP_RUN;
    cfg_data  <= pump_s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  // Random beats. upset (per mille) sets how often faults, the manual switch,
  // end of travel and off or invalid modes appear; keep it low so that runs
  // get deep into moving and watering. tick_pct sets the share of ticks.
  task automatic run_phase(input int count, input int upset, input int tick_pct);
    in_item_t it;
    int       r;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) quiet <= ($urandom_range(0, 3) == 0);
      // Let the result side catch up completely once per phase
      if (i == count / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < tick_pct) it.func = FUNC_TICK;
      else if (r < 96) it.func = FUNC_STEP;
      else if (r < 99) it.func = FUNC_MODE;
      else it.func = FUNC_UNUSED;
      if ($urandom_range(0, 999) < upset * 4) it.new_mode = 2'($urandom_range(0, 3));
      else it.new_mode = 2'($urandom_range(MODE_AUTO, MODE_ECO));
      if ($urandom_range(0, 999) < upset) it.fault_lines = 6'($urandom_range(1, 63));
      else it.fault_lines = 6'd0;
      it.manual_switch = ($urandom_range(0, 999) < upset);
      it.end_of_travel = ($urandom_range(0, 999) < upset);
      it.timer_ready   = 1'($urandom_range(0, 1));
      it.minute_of_day = 11'($urandom_range(0, 2047));
      // Bias the samples towards dry and hot so that runs start
      if ($urandom_range(0, 2) == 0) it.humidity_sample = 12'($urandom_range(0, HUM_DRY_RAW));
      else it.humidity_sample = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 2) == 0)
        it.temperature_sample = 12'($urandom_range(TEMP_HOT_RAW, 4095));
      else it.temperature_sample = 12'($urandom_range(0, 4095));
      it.humidity_digital    = 1'($urandom_range(0, 1));
      it.temperature_digital = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  initial begin
    in_item_t odd_beat;
    foreach (func_tally[k]) func_tally[k] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at the reset run times (6 s motor, 54 s pump).
    // A tick and a faulty step in the configuration state change nothing.
    send_item(tick_item(12'hFFF, 12'hFFF));
    send_item(step_item(6'h3F, 1'b1, 1'b1, 1'b0, 11'd0, 1'b1, 1'b1));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b1, 11'd0, 1'b0, 1'b0));
    // Invalid mode is flagged and the mode kept; off mode holds init
    send_item(mode_item(MODE_INVALID));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    // Eco: just outside the window at both ends, then its closing edge
    send_item(mode_item(MODE_ECO));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd301, 1'b0, 1'b0));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd1319, 1'b0, 1'b0));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd300, 1'b0, 1'b0));
    // Weather just short of both limits; one digital input is not enough
    send_item(tick_item(12'd820, 12'd3275));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd0, 1'b1, 1'b0));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd0, 1'b1, 1'b1));
    // End of travel closes a cycle
    send_item(step_item(6'h00, 1'b0, 1'b1, 1'b0, 11'd0, 1'b0, 1'b0));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    // Auto mode, hot at the limit, then run the motor out to watering
    send_item(mode_item(MODE_AUTO));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd2047, 1'b0, 1'b0));
    send_item(tick_item(12'd4095, 12'd3276));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    for (int n = 0; n < 6; n++) send_item(tick_item(12'd819, 12'd0));
    send_item(step_item(6'h00, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    // Manual and fault overrides, then fault with mode off falls to manual
    send_item(step_item(6'h00, 1'b1, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    send_item(step_item(6'h01, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    send_item(step_item(6'h00, 1'b1, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    send_item(mode_item(MODE_OFF));
    send_item(step_item(6'h20, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0, 1'b0));
    // The unused item kind only reports the state
    odd_beat      = mode_item(MODE_AUTO);
    odd_beat.func = FUNC_UNUSED;
    send_item(odd_beat);

    run_phase(250, 30, 45);
    drain_results();

    // Shortest run times
    write_run_times(MOTOR_RUN_MIN, PUMP_RUN_MIN);
    run_phase(250, 20, 45);
    drain_results();

    // Writes just below the minimum must be ignored
    write_run_times(MOTOR_RUN_MIN - 8'd1, PUMP_RUN_MIN - 8'd1);
    run_phase(200, 40, 40);
    drain_results();

    // Longest run times: tick-heavy and undisturbed so that watering is reached
    write_run_times(8'd255, 8'd255);
    run_phase(600, 0, 85);
    drain_results();

    // Any value, the ignored ones included
    write_run_times(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(200, 20, 50);
    drain_results();

    write_run_times(8'd40, 8'd20);
    run_phase(200, 15, 60);
    drain_results();

    $display("Covered %0d control steps, %0d ticks, %0d mode sets and %0d unused-kind beats",
             func_tally[FUNC_STEP], func_tally[FUNC_TICK], func_tally[FUNC_MODE],
             func_tally[FUNC_UNUSED]);
    $display("over %0d run-time settings; %0d results checked, states seen mask %b",
             settings_done, checked, states_seen);
    if (fail_count == 0) begin
      $display("irrigation_pivot_controller_tb: PASS");
    end else begin
      $display("irrigation_pivot_controller_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ipc_pkg.sv
rtl/core/ipc_step.sv
rtl/core/irrigation_pivot_controller.sv
rtl/core/ipc_checker.sv
tb/irrigation_pivot_controller_checker.sv
tb/irrigation_pivot_controller_tb.sv
